// ----- hw/rtl/bftr_pkg.sv -----
`timescale 1ns / 1ps

package bftr_pkg;

    // Field widths
    localparam int STORE_AW  = 13;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int HEIGHT_W  = 6;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int OPCODE_W  = 2;

    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPH_WIDTH    = 8;
    localparam int STORE_DEPTH    = 8192;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 2 * COORD_W + GLYPH_WIDTH * COLOR_W;

    // Input beat layout, lowest bit up
    localparam int S_ADDR_LSB   = 0;
    localparam int S_BYTE_LSB   = S_ADDR_LSB + STORE_AW;
    localparam int S_ORGX_LSB   = S_BYTE_LSB + BYTE_W;
    localparam int S_ORGY_LSB   = S_ORGX_LSB + COORD_W;
    localparam int S_CHAR_LSB   = S_ORGY_LSB + COORD_W;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ORIGIN = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DRAW   = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Register indexes
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_FOREGROUND = 2'd0;
    localparam logic [1:0] REG_BACKGROUND = 2'd1;
    localparam logic [1:0] REG_HEIGHT     = 2'd2;

    localparam logic [COLOR_W-1:0]  FOREGROUND_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0]  BACKGROUND_RESET = 32'h0000_0000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET     = 6'd16;

    typedef struct packed {
        logic load;      // write one glyph byte
        logic origin;    // set line start and cursor
        logic draw;      // start a glyph
        logic newline;   // carriage return and line feed
        logic issue;     // read one glyph row
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;   // a row read may be issued this cycle
        logic issue_last;  // the row about to be issued is the final one
        logic is_newline;  // character field holds the newline code
    } dp_status_t;

endpackage

// ----- hw/rtl/bftr_ctrl.sv -----
`timescale 1ns / 1ps

module bftr_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bftr_pkg::OPCODE_W-1:0] opcode,
    input  bftr_pkg::dp_status_t         status,
    output bftr_pkg::dp_cmd_t            cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load    = (opcode == bftr_pkg::OP_LOAD);
                    cmd.origin  = (opcode == bftr_pkg::OP_ORIGIN);
                    cmd.newline = (opcode == bftr_pkg::OP_DRAW) && status.is_newline;
                    cmd.draw    = (opcode == bftr_pkg::OP_DRAW) && !status.is_newline;
                    if (cmd.draw)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // issue one row whenever the read stage can move on
                cmd.issue = status.slot_free;
                if (status.slot_free && status.issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/bftr_datapath.sv -----
`timescale 1ns / 1ps

module bftr_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bftr_pkg::dp_cmd_t                   cmd,
    output bftr_pkg::dp_status_t                status,
    input  logic [bftr_pkg::S_TDATA_W-1:0]      in_data,
    input  logic [bftr_pkg::COLOR_W-1:0]        foreground_color,
    input  logic [bftr_pkg::COLOR_W-1:0]        background_color,
    input  logic [bftr_pkg::HEIGHT_W-1:0]       glyph_height,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bftr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int CW = bftr_pkg::COORD_W;
    localparam int KW = bftr_pkg::COLOR_W;
    localparam int BW = bftr_pkg::STORE_AW + bftr_pkg::HEIGHT_W;

    // Input fields
    logic [bftr_pkg::STORE_AW-1:0] store_address;
    logic [bftr_pkg::BYTE_W-1:0]   store_byte;
    logic [CW-1:0]                 origin_x;
    logic [CW-1:0]                 origin_y;
    logic [bftr_pkg::CHAR_W-1:0]   character;

    assign store_address = in_data[bftr_pkg::S_ADDR_LSB +: bftr_pkg::STORE_AW];
    assign store_byte    = in_data[bftr_pkg::S_BYTE_LSB +: bftr_pkg::BYTE_W];
    assign origin_x      = in_data[bftr_pkg::S_ORGX_LSB +: CW];
    assign origin_y      = in_data[bftr_pkg::S_ORGY_LSB +: CW];
    assign character     = in_data[bftr_pkg::S_CHAR_LSB +: bftr_pkg::CHAR_W];

    // Effective glyph height, clamped to 1..MAX_GLYPH_ROWS
    logic [bftr_pkg::HEIGHT_W-1:0] height_eff;

    always_comb
    begin
        if (glyph_height == '0)
        begin
            height_eff = bftr_pkg::HEIGHT_W'(1);
        end
        else if (glyph_height > bftr_pkg::HEIGHT_W'(bftr_pkg::MAX_GLYPH_ROWS))
        begin
            height_eff = bftr_pkg::HEIGHT_W'(bftr_pkg::MAX_GLYPH_ROWS);
        end
        else
        begin
            height_eff = glyph_height;
        end
    end

    // Cursor state
    logic [CW-1:0] cursor_x_reg;
    logic [CW-1:0] cursor_y_reg;
    logic [CW-1:0] line_start_x_reg;

    // Glyph being drawn
    logic [bftr_pkg::STORE_AW-1:0] base_reg;
    logic [CW-1:0]                 draw_x_reg;
    logic [CW-1:0]                 draw_y_reg;
    logic [bftr_pkg::ROW_W-1:0]    row_reg;
    logic [bftr_pkg::HEIGHT_W-1:0] row_plus_one;
    logic [bftr_pkg::STORE_AW-1:0] rd_addr;
    logic [BW-1:0]                 base_full;

    assign base_full    = BW'(character) * BW'(height_eff);
    assign row_plus_one = bftr_pkg::HEIGHT_W'(row_reg) + bftr_pkg::HEIGHT_W'(1);
    assign rd_addr      = base_reg + bftr_pkg::STORE_AW'(row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            line_start_x_reg <= '0;
            row_reg          <= '0;
        end
        else
        begin
            if (cmd.origin)
            begin
                line_start_x_reg <= origin_x;
                cursor_x_reg     <= origin_x;
                cursor_y_reg     <= origin_y;
            end
            else if (cmd.newline)
            begin
                cursor_x_reg <= line_start_x_reg;
                cursor_y_reg <= cursor_y_reg + CW'(height_eff);
            end
            else if (cmd.draw)
            begin
                cursor_x_reg <= cursor_x_reg + CW'(bftr_pkg::GLYPH_WIDTH);
            end

            if (cmd.draw)
            begin
                row_reg <= '0;
            end
            else if (cmd.issue)
            begin
                row_reg <= status.issue_last ? '0 : row_reg + bftr_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            base_reg   <= base_full[bftr_pkg::STORE_AW-1:0];
            draw_x_reg <= cursor_x_reg;
            draw_y_reg <= cursor_y_reg;
        end
    end

    // Glyph store, one write port and one registered read port
    logic [bftr_pkg::BYTE_W-1:0] glyph_store [bftr_pkg::STORE_DEPTH];
    logic [bftr_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_store[store_address] <= store_byte;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= glyph_store[rd_addr];
        end
    end

    // Read stage side data
    logic          rd_valid_reg;
    logic [CW-1:0] rd_x_reg;
    logic [CW-1:0] rd_y_reg;
    logic          rd_last_reg;
    logic          out_load;

    assign out_load          = rd_valid_reg && (!m_tvalid || m_tready);
    assign status.slot_free  = !rd_valid_reg || out_load;
    assign status.issue_last = (row_plus_one == height_eff);
    assign status.is_newline = (character == bftr_pkg::NEWLINE_CODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            rd_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_x_reg    <= draw_x_reg;
            rd_y_reg    <= draw_y_reg + CW'(row_reg);
            rd_last_reg <= status.issue_last;
        end
    end

    // Output register
    logic                          m_tvalid_reg;
    logic [bftr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tlast_reg;
    logic [bftr_pkg::M_TDATA_W-1:0] row_beat;

    always_comb
    begin
        row_beat[0 +: CW]  = rd_x_reg;
        row_beat[CW +: CW] = rd_y_reg;
        for (int k = 0; k < bftr_pkg::GLYPH_WIDTH; k++)
        begin
            row_beat[2*CW + k*KW +: KW] = rd_data_reg[bftr_pkg::GLYPH_WIDTH-1-k]
                                          ? foreground_color : background_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= row_beat;
            m_tlast_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // a read row that cannot move on keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && !status.slot_free) |=> (rd_valid_reg && $stable(rd_data_reg)))
        else $error("read stage lost or changed a stalled row");

    // an issued read always lands in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> rd_valid_reg)
        else $error("issued row not held in read stage");

    // a row moved to the output is presented next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg)
        else $error("row moved to output but no beat presented");
`endif

endmodule

// ----- hw/rtl/bitmap_font_text_renderer.sv -----
`timescale 1ns / 1ps

// Character generator for 8-pixel-wide bitmap fonts. Each input beat carries
// an opcode in s_tuser: load one glyph byte into the 8192-byte glyph store,
// set the text origin (which also moves the cursor), or draw one character.
// Drawing a newline only moves the cursor; any other code sends one output
// beat per glyph row holding the row position and eight 32-bit colors
// (foreground for a set bit, background for a clear bit, MSB leftmost), with
// m_tlast on the final row. A drawn character is started when its beat is
// accepted, then one glyph row is read from the glyph store per cycle; if
// m_tready backpressure holds the output register, the read stage waits and
// row reads stall. Glyph bytes must be loaded before they are drawn. Write
// the color and height registers only while no draw is in progress.
module bitmap_font_text_renderer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // store_address[12:0], store_byte[20:13], origin_x[36:21],
    // origin_y[52:37], character[60:53], zero fill [63:61]
    input  logic [bftr_pkg::S_TDATA_W-1:0]       s_tdata,
    // opcode[1:0]
    input  logic [bftr_pkg::OPCODE_W-1:0]        s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // row_x[15:0], row_y[31:16], pixel_color_0[63:32] ... pixel_color_7[287:256]
    output logic [bftr_pkg::M_TDATA_W-1:0]       m_tdata,
    // last_row
    output logic                                 m_tlast,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bftr_pkg::APB_AW-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Configuration registers
    logic [bftr_pkg::COLOR_W-1:0]  foreground_reg;
    logic [bftr_pkg::COLOR_W-1:0]  background_reg;
    logic [bftr_pkg::HEIGHT_W-1:0] height_reg;
    logic                          reg_write;
    logic [1:0]                    reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreground_reg <= bftr_pkg::FOREGROUND_RESET;
            background_reg <= bftr_pkg::BACKGROUND_RESET;
            height_reg     <= bftr_pkg::HEIGHT_RESET;
        end
        else if (reg_write)
        begin
            unique case (reg_index)
                bftr_pkg::REG_FOREGROUND: foreground_reg <= pwdata;
                bftr_pkg::REG_BACKGROUND: background_reg <= pwdata;
                bftr_pkg::REG_HEIGHT:     height_reg     <= pwdata[bftr_pkg::HEIGHT_W-1:0];
                default:                  ; // drop writes to unmapped addresses
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_index)
            bftr_pkg::REG_FOREGROUND: prdata = foreground_reg;
            bftr_pkg::REG_BACKGROUND: prdata = background_reg;
            bftr_pkg::REG_HEIGHT:     prdata = 32'(height_reg);
            default:                  prdata = '0;
        endcase
    end

    // Controller and datapath
    bftr_pkg::dp_cmd_t    cmd;
    bftr_pkg::dp_status_t status;

    bftr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    bftr_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_data          (s_tdata),
        .foreground_color (foreground_reg),
        .background_color (background_reg),
        .glyph_height     (height_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

endmodule
